@@ rtl/core/pss_pkg.sv @@
// shared types and codes for the positional sequence store
// no dependencies; imported by the store top level and its entry ram

package pss_pkg;

   localparam int WORD_W = 32;
   localparam int LEN_W  = 7;
   localparam int POS_W  = 6;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [1:0]               op_type;
   typedef logic [1:0]               status_type;
   typedef logic [POS_W-1:0]         pos_type;
   typedef logic [LEN_W-1:0]         len_type;

   localparam op_type OP_APPEND = 2'd0;
   localparam op_type OP_REMOVE = 2'd1;
   localparam op_type OP_INSERT = 2'd2;
   localparam op_type OP_DELETE = 2'd3;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_RANGE = 2'd2;
   localparam status_type ST_FULL  = 2'd3;

endpackage

@@ rtl/core/pss_entry_ram.sv @@
// entry storage for the positional sequence store: one write port and one
// read port with registered read data; depends on pss_pkg

module pss_entry_ram #(
   parameter int DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  pss_pkg::word_type         wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output pss_pkg::word_type         rd_data
);
   import pss_pkg::*;

   word_type mem [DEPTH];
   word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/positional_sequence_store.sv @@
// positional sequence store: bounded ordered list of signed 32-bit values
// depends on pss_pkg and pss_entry_ram
//
// usage: each request on req_ names an operation (append at tail, remove
// head, insert at position, delete at position) and returns exactly one
// response on rsp_ with a status, the value taken by remove head and the
// length after the operation. entries live in a ram; one step unit walks a
// cursor over it, moving one entry at a time (ram read, then write).
// entries moved per operation:
//   append or any error: none
//   insert at p: count-p, each one position up
//   delete at p: count-1-p, each one position down
//   remove head: count-1 down, after the head entry is read out
// the ram's single read port and the one shared cursor adder set this
// one-at-a-time walk; req_tready is low while a request is in work.
// a finished response sits in an output register, so the next request is
// taken while rsp_tready is low; a second finished response then waits
// until the first is taken. reset empties the store at once (no sweep).

module positional_sequence_store #(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // operation[1:0], position[7:2], item_value[39:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // status[1:0], removed_value[33:2], length[40:34], zero
);
   import pss_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_HEAD = 3'd1;
   localparam logic [2:0] S_GRAB = 3'd2;
   localparam logic [2:0] S_READ = 3'd3;
   localparam logic [2:0] S_MOVE = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] cursor_ff, cursor_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic              ins_ff, ins_in;
   word_type          val_ff, val_in;
   word_type          removed_ff, removed_in;
   status_type        status_ff, status_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        out_status_ff, out_status_in;
   word_type          out_removed_ff, out_removed_in;
   len_type           out_length_ff, out_length_in;

   op_type            req_op;
   pos_type           req_pos;
   word_type          req_val;
   logic              accept;
   logic [CMP_W-1:0]  cnt_c, pos_c;
   logic              is_full, is_empty;

   logic [CNT_W-1:0]  step_c;
   logic [ADDR_W-1:0] step;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   word_type          wr_data, rd_data;
   logic              out_free;

   assign req_op  = req_tdata[1:0];
   assign req_pos = req_tdata[7:2];
   assign req_val = req_tdata[39:8];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign cnt_c    = CMP_W'(count_ff);
   assign pos_c    = CMP_W'(req_pos);
   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);

   // shared step unit: the cursor moves down for insert, up for delete and remove head
   assign step_c = ins_ff ? (CNT_W'(cursor_ff) - CNT_W'(1))
                          : (CNT_W'(cursor_ff) + CNT_W'(1));
   assign step   = step_c[ADDR_W-1:0];

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      cursor_in  = cursor_ff;
      pos_in     = pos_ff;
      ins_in     = ins_ff;
      val_in     = val_ff;
      removed_in = removed_ff;
      status_in  = status_ff;
      wr_en      = 1'b0;
      wr_addr    = cursor_ff;
      wr_data    = rd_data;
      rd_en      = 1'b0;
      rd_addr    = step;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               removed_in = '0;
               status_in  = ST_OK;
               val_in     = req_val;
               pos_in     = ADDR_W'(req_pos);
               state_in   = S_DONE;
               unique case (req_op)
                  OP_APPEND: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = ADDR_W'(count_ff);
                        wr_data  = req_val;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_REMOVE: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        cursor_in = '0;
                        ins_in    = 1'b0;
                        state_in  = S_HEAD;
                     end
                  end
                  OP_INSERT: begin
                     if (pos_c > cnt_c) begin
                        status_in = ST_RANGE;
                     end else if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        cursor_in = ADDR_W'(count_ff);
                        ins_in    = 1'b1;
                        state_in  = S_READ;
                     end
                  end
                  default: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else if (pos_c >= cnt_c) begin
                        status_in = ST_RANGE;
                     end else begin
                        cursor_in = ADDR_W'(req_pos);
                        ins_in    = 1'b0;
                        state_in  = S_READ;
                     end
                  end
               endcase
            end
         end
         S_HEAD: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = S_GRAB;
         end
         S_GRAB: begin
            removed_in = rd_data;
            state_in   = S_READ;
         end
         S_READ: begin
            if (ins_ff) begin
               if (cursor_ff == pos_ff) begin
                  wr_en    = 1'b1;
                  wr_data  = val_ff;
                  count_in = count_ff + CNT_W'(1);
                  state_in = S_DONE;
               end else begin
                  rd_en    = 1'b1;
                  state_in = S_MOVE;
               end
            end else begin
               if (step_c < count_ff) begin
                  rd_en    = 1'b1;
                  state_in = S_MOVE;
               end else begin
                  count_in = count_ff - CNT_W'(1);
                  state_in = S_DONE;
               end
            end
         end
         S_MOVE: begin
            wr_en     = 1'b1;
            cursor_in = step;
            state_in  = S_READ;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      out_status_in  = out_status_ff;
      out_removed_in = out_removed_ff;
      out_length_in  = out_length_ff;
      if (state_ff == S_DONE && out_free) begin
         rsp_valid_in   = 1'b1;
         out_status_in  = status_ff;
         out_removed_in = removed_ff;
         out_length_in  = LEN_W'(count_ff);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cursor_ff      <= cursor_in;
      pos_ff         <= pos_in;
      ins_ff         <= ins_in;
      val_ff         <= val_in;
      removed_ff     <= removed_in;
      status_ff      <= status_in;
      out_status_ff  <= out_status_in;
      out_removed_ff <= out_removed_in;
      out_length_ff  <= out_length_in;
   end

   pss_entry_ram #(
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, out_length_ff, out_removed_ff, out_status_ff};

   // length never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // each request changes the length by at most one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |->
         (count_ff == $past(count_ff) + CNT_W'(1)) ||
         (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("entry count jumped");

   // a failed request never reports a removed value
   a_err_no_value: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && status_ff != ST_OK) |-> removed_ff == '0)
      else $error("removed value on failed request");

endmodule
